@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the convolution reverb block.
// Depends on nothing; taken in by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("check failed: invariant");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

@@ design/crwd_pkg.sv @@
// Constants and request codes for the convolution reverb with wet/dry mix.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package crwd_pkg;

   // History and tap store depth; a power of two so pointers wrap naturally
   localparam int MAX_TAPS   = 4096;
   localparam int ADDR_W     = $clog2(MAX_TAPS);
   localparam int LEN_W      = ADDR_W + 1;

   localparam int TYPE_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int TAP_IDX_W  = 12;
   localparam int WET_W      = 16;
   localparam int IRLEN_W    = 13;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Q1.15 x Q1.15 product and its exact sum over the whole store
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = PROD_W + ADDR_W;
   // 17-bit signed mix coefficient times a 16-bit sample, and their sum
   localparam int MIX_W      = WET_W + 1 + SAMPLE_W;
   localparam int SUM_W      = MIX_W + 1;

   localparam int RND_SHIFT  = 15;

   localparam logic [TYPE_W-1:0] REQ_SAMPLE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_TAP    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IR_LENGTH = 1'd1;

   localparam logic [WET_W-1:0]   WET_ONE     = 16'd32768;
   localparam logic [WET_W-1:0]   WET_RESET   = 16'd16384;
   localparam logic [IRLEN_W-1:0] IRLEN_RESET = 13'd0;

endpackage

`default_nettype wire

@@ design/crwd_ifs.sv @@
// Valid/ready channel interfaces: request, response and register write.
// Depends on crwd_pkg for field widths.
`default_nettype none

interface crwd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [crwd_pkg::TYPE_W-1:0]     req_type;
   logic signed [crwd_pkg::SAMPLE_W-1:0]   sample_in;
   logic        [crwd_pkg::TAP_IDX_W-1:0]  tap_index;
   logic signed [crwd_pkg::SAMPLE_W-1:0]   tap_value;

   modport source (output valid, req_type, sample_in, tap_index, tap_value, input ready);
   modport sink   (input valid, req_type, sample_in, tap_index, tap_value, output ready);
endinterface

interface crwd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [crwd_pkg::SAMPLE_W-1:0]   sample_out;
   logic                                   out_valid;
   logic                                   clipped;

   modport source (output valid, sample_out, out_valid, clipped, input ready);
   modport sink   (input valid, sample_out, out_valid, clipped, output ready);
endinterface

interface crwd_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [crwd_pkg::CSR_IDX_W-1:0]         reg_index;
   logic [crwd_pkg::CSR_DATA_W-1:0]        wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ design/crwd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/convolution_reverb_wet_dry.sv @@
// Top level: FIR convolution reverb with wet/dry mix over two RAMs.
// Depends on crwd_pkg, crwd_ifs, crwd_ram and assert_macros.svh.
//
//   channel  dir  handshake     word
//   req_ch   in   valid/ready   req_type, sample_in, tap_index, tap_value
//   rsp_ch   out  valid/ready   sample_out, out_valid, clipped
//   csr_ch   in   valid/ready   reg_index, wr_data (0 wet_mix, 1 ir_length)
//
// Audio word: L = min(ir_length, 4096) products, summed by the one
// multiply-accumulate per cycle over the tap and history RAMs.
// Tap write, clear, unknown word or L = 0: no MAC run; result goes via ST_DONE.
// Reset is synchronous; history reads as zero through a fill count.
// One word in flight; a finished result waits in the output register while
// the next word is accepted. Register writes are taken every cycle.
`default_nettype none
`include "assert_macros.svh"

module convolution_reverb_wet_dry (
   input  wire logic   clock,
   input  wire logic   reset,
   crwd_req_if.sink    req_ch,
   crwd_rsp_if.source  rsp_ch,
   crwd_csr_if.sink    csr_ch
);

   localparam int AW = crwd_pkg::ADDR_W;
   localparam int LW = crwd_pkg::LEN_W;
   localparam int SW = crwd_pkg::SAMPLE_W;
   localparam int PW = crwd_pkg::PROD_W;
   localparam int CW = crwd_pkg::ACC_W;
   localparam int MW = crwd_pkg::MIX_W;
   localparam int UW = crwd_pkg::SUM_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_WET   = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [AW-1:0] PTR_LAST = AW'(crwd_pkg::MAX_TAPS - 1);
   localparam logic [LW-1:0] LEN_MAX  = LW'(crwd_pkg::MAX_TAPS);

   localparam logic signed [CW-1:0] ACC_HALF = CW'(16384);
   localparam logic signed [CW-1:0] ACC_HI   = CW'(32767);
   localparam logic signed [CW-1:0] ACC_LO   = -CW'(32768);
   localparam logic signed [UW-1:0] SUM_HALF = UW'(16384);
   localparam logic signed [UW-1:0] SUM_HI   = UW'(32767);
   localparam logic signed [UW-1:0] SUM_LO   = -UW'(32768);

   // ---------------- registers ----------------
   logic [2:0]                    state_ff, state_in;
   logic [crwd_pkg::WET_W-1:0]    wet_mix_ff, wet_mix_in;
   logic [crwd_pkg::IRLEN_W-1:0]  ir_length_ff, ir_length_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [LW-1:0]                 fill_ff, fill_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [LW-1:0]                 len_ff, len_in;
   logic [LW-1:0]                 k_ff, k_in;
   logic signed [SW-1:0]          x_ff, x_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          hv_ff, hv_in;
   logic                          mul_vld_ff, mul_vld_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [CW-1:0]          acc_ff, acc_in;
   logic signed [SW-1:0]          w_ff, w_in;
   logic signed [MW-1:0]          dry_ff, dry_in;
   logic signed [MW-1:0]          wetp_ff, wetp_in;
   logic                          clip_ff, clip_in;
   logic signed [SW-1:0]          res_smp_ff, res_smp_in;
   logic                          res_ov_ff, res_ov_in;
   logic                          res_clip_ff, res_clip_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic signed [SW-1:0]          rsp_smp_ff, rsp_smp_in;
   logic                          rsp_ov_ff, rsp_ov_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   // ---------------- combinational ----------------
   logic                          req_acc;
   logic                          rsp_free;
   logic [crwd_pkg::WET_W-1:0]    wet_eff;
   logic [crwd_pkg::WET_W-1:0]    dry_coef;
   logic [LW-1:0]                 len_eff;
   logic                          hist_we;
   logic                          tap_we;
   logic [AW-1:0]                 hist_raddr;
   logic [AW-1:0]                 tap_raddr;
   logic [SW-1:0]                 hist_rd;
   logic [SW-1:0]                 tap_rd;
   logic signed [SW-1:0]          hist_val;
   logic signed [CW-1:0]          acc_rnd;
   logic signed [CW-1:0]          acc_sh;
   logic signed [UW-1:0]          sum_rnd;
   logic signed [UW-1:0]          sum_sh;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.sample_out = rsp_smp_ff;
   assign rsp_ch.out_valid  = rsp_ov_ff;
   assign rsp_ch.clipped    = rsp_clip_ff;

   assign wet_eff  = (wet_mix_ff > crwd_pkg::WET_ONE) ? crwd_pkg::WET_ONE : wet_mix_ff;
   assign dry_coef = crwd_pkg::WET_ONE - wet_eff;
   assign len_eff  = (32'(ir_length_ff) > 32'(crwd_pkg::MAX_TAPS)) ? LEN_MAX
                                                                   : LW'(ir_length_ff);

   assign hist_we = req_acc && (req_ch.req_type == crwd_pkg::REQ_SAMPLE);
   assign tap_we  = req_acc && (req_ch.req_type == crwd_pkg::REQ_TAP)
                    && (32'(req_ch.tap_index) < 32'(crwd_pkg::MAX_TAPS));

   // Tap k pairs with the sample k words back from the newest one
   assign tap_raddr  = k_ff[AW-1:0];
   assign hist_raddr = base_ff - k_ff[AW-1:0];

   crwd_ram #(.WIDTH(SW), .DEPTH(crwd_pkg::MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (ptr_ff),
      .wr_data (req_ch.sample_in),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   crwd_ram #(.WIDTH(SW), .DEPTH(crwd_pkg::MAX_TAPS)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (req_ch.tap_index[AW-1:0]),
      .wr_data (req_ch.tap_value),
      .rd_addr (tap_raddr),
      .rd_data (tap_rd)
   );

   // Entries at or past the fill count hold no valid sample and read as zero
   assign hist_val = hv_ff ? $signed(hist_rd) : '0;

   assign acc_rnd = acc_ff + ACC_HALF;
   assign acc_sh  = acc_rnd >>> crwd_pkg::RND_SHIFT;
   assign sum_rnd = (UW'(dry_ff) + UW'(wetp_ff)) + SUM_HALF;
   assign sum_sh  = sum_rnd >>> crwd_pkg::RND_SHIFT;

   always_comb begin
      state_in     = state_ff;
      wet_mix_in   = wet_mix_ff;
      ir_length_in = ir_length_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      base_in      = base_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      dry_in       = dry_ff;
      wetp_in      = wetp_ff;
      clip_in      = clip_ff;
      res_smp_in   = res_smp_ff;
      res_ov_in    = res_ov_ff;
      res_clip_in  = res_clip_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_smp_in   = rsp_smp_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_clip_in  = rsp_clip_ff;

      // MAC pipeline: address, RAM data, product, accumulate
      rd_vld_in  = (state_ff == ST_RUN);
      hv_in      = ({1'b0, hist_raddr} < fill_ff);
      mul_vld_in = rd_vld_ff;
      prod_in    = PW'($signed(tap_rd) * hist_val);
      if (mul_vld_ff) begin
         acc_in = acc_ff + CW'(prod_ff);
      end

      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            crwd_pkg::CSR_WET_MIX:   wet_mix_in   = csr_ch.wr_data[crwd_pkg::WET_W-1:0];
            crwd_pkg::CSR_IR_LENGTH: ir_length_in = csr_ch.wr_data[crwd_pkg::IRLEN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_smp_in  = '0;
               res_ov_in   = 1'b0;
               res_clip_in = 1'b0;
               state_in    = ST_DONE;
               priority case (req_ch.req_type)
                  crwd_pkg::REQ_SAMPLE: begin
                     ptr_in    = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
                     fill_in   = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + 1'b1;
                     base_in   = ptr_ff;
                     len_in    = len_eff;
                     x_in      = req_ch.sample_in;
                     k_in      = '0;
                     acc_in    = '0;
                     res_ov_in = 1'b1;
                     if (len_eff != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  crwd_pkg::REQ_CLEAR: begin
                     ptr_in  = '0;
                     fill_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (k_ff == len_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_WET;
            end
         end
         ST_WET: begin
            priority if (acc_sh > ACC_HI) begin
               w_in    = SW'(ACC_HI);
               clip_in = 1'b1;
            end else if (acc_sh < ACC_LO) begin
               w_in    = SW'(ACC_LO);
               clip_in = 1'b1;
            end else begin
               w_in    = SW'(acc_sh);
               clip_in = 1'b0;
            end
            dry_in   = MW'($signed({1'b0, dry_coef}) * x_ff);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            wetp_in  = MW'($signed({1'b0, wet_eff}) * w_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            priority if (sum_sh > SUM_HI) begin
               res_smp_in  = SW'(SUM_HI);
               res_clip_in = 1'b1;
            end else if (sum_sh < SUM_LO) begin
               res_smp_in  = SW'(SUM_LO);
               res_clip_in = 1'b1;
            end else begin
               res_smp_in  = SW'(sum_sh);
               res_clip_in = clip_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_smp_in  = res_smp_ff;
               rsp_ov_in   = res_ov_ff;
               rsp_clip_in = res_clip_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wet_mix_ff   <= crwd_pkg::WET_RESET;
         ir_length_ff <= crwd_pkg::IRLEN_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wet_mix_ff   <= wet_mix_in;
         ir_length_ff <= ir_length_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      x_ff        <= x_in;
      hv_ff       <= hv_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      w_ff        <= w_in;
      dry_ff      <= dry_in;
      wetp_ff     <= wetp_in;
      clip_ff     <= clip_in;
      res_smp_ff  <= res_smp_in;
      res_ov_ff   <= res_ov_in;
      res_clip_ff <= res_clip_in;
      rsp_smp_ff  <= rsp_smp_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   // ---------------- checks ----------------
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= LEN_MAX)
   `ASSERT_IMPLY(a_run_in_range, clock, reset, state_ff == ST_RUN, k_ff < len_ff)
   `ASSERT_IMPLY(a_mac_drained, clock, reset,
                 state_ff == ST_WET || state_ff == ST_MIX || state_ff == ST_FIN,
                 !rd_vld_ff && !mul_vld_ff)
   `ASSERT_NEXT(a_sample_start, clock, reset,
                req_acc && req_ch.req_type == crwd_pkg::REQ_SAMPLE,
                state_ff == ST_RUN || state_ff == ST_DONE)

endmodule

`default_nettype wire
